FILE: hdl/mkcd_pkg.sv
// Shared constants and types for the median knob change detector.
`default_nettype none

package mkcd_pkg;

  localparam int GROUP_SIZE = 11;
  localparam int MEDIAN_POS = GROUP_SIZE / 2;

  localparam int SAMPLE_W = 10;
  localparam int SCALE_W  = 16;
  localparam int VALUE_W  = 10;
  localparam int CFG_W    = 16;
  localparam int INDEX_W  = 2;
  localparam int PROD_W   = SAMPLE_W + SCALE_W;
  localparam int FRAC_W   = 8;

  localparam int CNT_W  = $clog2(GROUP_SIZE + 1);
  localparam int ADDR_W = $clog2(GROUP_SIZE);

  localparam int S_DATA_W = 16;
  localparam int M_DATA_W = 24;

  localparam logic [VALUE_W-1:0] VALUE_MAX = '1;

  typedef enum logic [INDEX_W-1:0] {
    REG_MAX_MEASURE      = 2'd0,
    REG_SCALE_FACTOR     = 2'd1,
    REG_CHANGE_THRESHOLD = 2'd2,
    REG_STABLE_THRESHOLD = 2'd3
  } reg_index_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FIRST,
    ST_SCAN,
    ST_NORM,
    ST_HIST,
    ST_OUT
  } state_t;

endpackage

`default_nettype wire

FILE: hdl/median_knob_change_detector.sv
// Top level of the median knob change detector: sample store, median search, scaling, history.
`default_nettype none

// Samples are collected in groups of GROUP_SIZE. Each sample that does not close a group is
// simply stored. The sample that closes a group starts the median search: each stored sample
// in turn is a candidate, and one comparator walks the store through its single read port,
// a full pass per candidate, until the candidate at the middle sorted position is found. The
// Q8.8 scaling then follows in a registered multiplier (ST_NORM) and the history update in
// ST_HIST, after which the result waits in the output register. From the closing sample
// until the result is handed to the output register, the block is not ready for samples.
// A waiting result does not block the first samples of the next group.
module median_knob_change_detector
  import mkcd_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  // configuration write port
  input  wire logic                cfg_we,
  input  wire logic [INDEX_W-1:0]  cfg_index,
  input  wire logic [CFG_W-1:0]    cfg_data,
  // sample stream
  input  wire logic                s_tvalid,
  output logic                     s_tready,
  input  wire logic [S_DATA_W-1:0] s_tdata,   // [9:0] sample, [15:10] zero
  // result stream
  output logic                     m_tvalid,
  input  wire logic                m_tready,
  output logic [M_DATA_W-1:0]      m_tdata    // [9:0] reading, [19:10] previous_reading,
                                              // [20] changed_stable, [23:21] zero
);

  state_t state, state_next;

  logic [SAMPLE_W-1:0] max_measure;
  logic [SCALE_W-1:0]  scale_factor;
  logic [VALUE_W-1:0]  change_threshold;
  logic [VALUE_W-1:0]  stable_threshold;

  logic [SAMPLE_W-1:0] mem [GROUP_SIZE];
  logic [ADDR_W-1:0]   raddr;
  logic [SAMPLE_W-1:0] rd_data;

  logic [CNT_W-1:0]    sample_count;
  logic [ADDR_W-1:0]   cand_idx;
  logic [CNT_W-1:0]    scan_cnt;
  logic [CNT_W-1:0]    less_cnt;
  logic [CNT_W-1:0]    le_cnt;
  logic [SAMPLE_W-1:0] cand;
  logic [SAMPLE_W-1:0] median;
  logic [PROD_W-1:0]   prod;

  logic [VALUE_W-1:0]  current_value;
  logic [VALUE_W-1:0]  last_value;
  logic                change_pending;
  logic                pulse;

  logic [VALUE_W-1:0]  out_reading;
  logic [VALUE_W-1:0]  out_previous;
  logic                out_changed;

  logic                in_fire;
  logic                group_done;
  logic                scan_end;
  logic                lt_bit;
  logic                le_bit;
  logic [CNT_W-1:0]    less_sum;
  logic [CNT_W-1:0]    le_sum;
  logic                found;
  logic                out_free;

  logic [VALUE_W-1:0]  value_new;
  logic [VALUE_W-1:0]  last_new;
  logic [VALUE_W-1:0]  older_new;
  logic [VALUE_W-1:0]  var_d;
  logic [VALUE_W-1:0]  pvar_d;
  logic [VALUE_W-1:0]  gvar_d;
  logic                stable;
  logic                pending_next;
  logic                pulse_next;

  function automatic logic [VALUE_W-1:0] abs_diff(input logic [VALUE_W-1:0] a,
                                                  input logic [VALUE_W-1:0] b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

  assign in_fire    = s_tvalid && s_tready;
  assign group_done = (sample_count == CNT_W'(GROUP_SIZE - 1));
  assign scan_end   = (scan_cnt == CNT_W'(GROUP_SIZE));
  assign out_free   = !m_tvalid || m_tready;

  // shared comparator: stored sample against the current candidate
  assign lt_bit   = (rd_data < cand);
  assign le_bit   = (rd_data <= cand);
  assign less_sum = less_cnt + CNT_W'(lt_bit);
  assign le_sum   = le_cnt + CNT_W'(le_bit);
  assign found    = (less_sum <= CNT_W'(MEDIAN_POS)) && (le_sum > CNT_W'(MEDIAN_POS));

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (in_fire && group_done) state_next = ST_FIRST;
      ST_FIRST: state_next = ST_SCAN;
      ST_SCAN:  if (scan_end && found) state_next = ST_NORM;
      ST_NORM:  state_next = ST_HIST;
      ST_HIST:  state_next = ST_OUT;
      ST_OUT:   if (out_free) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    s_tready = 1'b0;
    raddr    = cand_idx;
    unique case (state)
      ST_IDLE:  s_tready = 1'b1;
      ST_FIRST: raddr = cand_idx;
      ST_SCAN: begin
        // at the end of a pass, fetch the next candidate
        if (scan_end) raddr = cand_idx + ADDR_W'(1);
        else          raddr = scan_cnt[ADDR_W-1:0];
      end
      default:  raddr = cand_idx;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      max_measure      <= SAMPLE_W'(1023);
      scale_factor     <= SCALE_W'(256);
      change_threshold <= VALUE_W'(8);
      stable_threshold <= VALUE_W'(4);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MAX_MEASURE:      max_measure      <= cfg_data[SAMPLE_W-1:0];
        REG_SCALE_FACTOR:     scale_factor     <= cfg_data[SCALE_W-1:0];
        REG_CHANGE_THRESHOLD: change_threshold <= cfg_data[VALUE_W-1:0];
        REG_STABLE_THRESHOLD: stable_threshold <= cfg_data[VALUE_W-1:0];
        default: ;
      endcase
    end
  end

  // sample store
  always_ff @(posedge clk) begin
    if (in_fire) mem[sample_count[ADDR_W-1:0]] <= s_tdata[SAMPLE_W-1:0];
    rd_data <= mem[raddr];
  end

  // history update on the new value
  always_comb begin
    if (prod[PROD_W-1:FRAC_W+VALUE_W] != '0) value_new = VALUE_MAX;
    else                                     value_new = prod[FRAC_W+VALUE_W-1:FRAC_W];
    older_new = last_value;
    last_new  = current_value;
    // align the history while the older value is still zero
    if (older_new == '0) begin
      older_new = value_new;
      last_new  = value_new;
    end
    var_d  = abs_diff(value_new, last_new);
    pvar_d = abs_diff(last_new, older_new);
    gvar_d = abs_diff(value_new, older_new);
    pending_next = change_pending;
    if (var_d > change_threshold) begin
      // a swing that comes back does not count
      pending_next = !(gvar_d < change_threshold);
    end
    stable     = (var_d < stable_threshold) && (pvar_d < stable_threshold);
    pulse_next = pending_next && stable;
    if (pulse_next) pending_next = 1'b0;
  end

  // sequencer datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_count   <= '0;
      cand_idx       <= '0;
      scan_cnt       <= '0;
      less_cnt       <= '0;
      le_cnt         <= '0;
      current_value  <= '0;
      last_value     <= '0;
      change_pending <= 1'b0;
      pulse          <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          cand_idx <= '0;
          if (in_fire) begin
            if (group_done) sample_count <= '0;
            else            sample_count <= sample_count + CNT_W'(1);
          end
        end
        ST_FIRST: begin
          scan_cnt <= '0;
          less_cnt <= '0;
          le_cnt   <= '0;
        end
        ST_SCAN: begin
          if (scan_cnt == '0) begin
            cand <= rd_data;
          end else begin
            less_cnt <= less_sum;
            le_cnt   <= le_sum;
          end
          if (scan_end) begin
            median   <= cand;
            cand_idx <= cand_idx + ADDR_W'(1);
            scan_cnt <= '0;
            less_cnt <= '0;
            le_cnt   <= '0;
          end else begin
            scan_cnt <= scan_cnt + CNT_W'(1);
          end
        end
        ST_NORM: begin
          if (median < max_measure)
            prod <= PROD_W'(max_measure - median) * PROD_W'(scale_factor);
          else
            prod <= '0;
        end
        ST_HIST: begin
          current_value  <= value_new;
          last_value     <= last_new;
          change_pending <= pending_next;
          pulse          <= pulse_next;
        end
        default: ;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == ST_OUT && out_free) begin
      m_tvalid     <= 1'b1;
      out_reading  <= current_value;
      out_previous <= last_value;
      out_changed  <= pulse;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  assign m_tdata = {3'b000, out_changed, out_previous, out_reading};

endmodule

`default_nettype wire

FILE: tb/knob_result_checker.sv
// Checker for the median knob change detector: predicts each result and compares it.
`default_nettype none

module knob_result_checker
  import mkcd_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cfg_we,
  input  wire logic [INDEX_W-1:0]  cfg_index,
  input  wire logic [CFG_W-1:0]    cfg_data,
  input  wire logic                s_tvalid,
  input  wire logic                s_tready,
  input  wire logic [S_DATA_W-1:0] s_tdata,   // [9:0] sample, [15:10] zero
  input  wire logic                m_tvalid,
  input  wire logic                m_tready,
  input  wire logic [M_DATA_W-1:0] m_tdata,   // [9:0] reading, [19:10] previous_reading,
                                              // [20] changed_stable, [23:21] zero
  output int                       mismatch_count,
  output int                       pending_results,
  output int                       results_seen,
  output int                       pulses_seen
);

  typedef struct packed {
    logic [M_DATA_W-2*VALUE_W-2:0] pad;
    logic                          changed_stable;
    logic [VALUE_W-1:0]            previous_reading;
    logic [VALUE_W-1:0]            reading;
  } knob_result_t;

  // register copies
  logic [SAMPLE_W-1:0] knob_max;
  logic [SCALE_W-1:0]  knob_gain;
  logic [VALUE_W-1:0]  change_limit;
  logic [VALUE_W-1:0]  settle_limit;

  // predicted block state
  logic [SAMPLE_W-1:0] group_store [GROUP_SIZE];
  int                  group_fill;
  logic [VALUE_W-1:0]  value_now;
  logic [VALUE_W-1:0]  value_last;
  logic [VALUE_W-1:0]  value_older;
  logic                change_armed;

  knob_result_t        expected_results [$];
  int                  errors;
  int                  matched;
  int                  pulses;

  function automatic logic [SAMPLE_W-1:0] group_median();
    logic [SAMPLE_W-1:0] sorted [GROUP_SIZE];
    logic [SAMPLE_W-1:0] key;
    int                  j;
    for (int i = 0; i < GROUP_SIZE; i++) sorted[i] = group_store[i];
    for (int i = 1; i < GROUP_SIZE; i++) begin
      key = sorted[i];
      j = i - 1;
      while (j >= 0 && sorted[j] > key) begin
        sorted[j + 1] = sorted[j];
        j--;
      end
      sorted[j + 1] = key;
    end
    return sorted[MEDIAN_POS];
  endfunction

  // inverted Q8.8 scale, truncated and clamped to the value range
  function automatic logic [VALUE_W-1:0] scale_median(logic [SAMPLE_W-1:0] med);
    logic [PROD_W-1:0]        prod;
    logic [PROD_W-FRAC_W-1:0] whole;
    if (med >= knob_max) return '0;
    prod = (knob_max - med) * knob_gain;
    whole = prod[PROD_W-1:FRAC_W];
    return (whole > VALUE_MAX) ? VALUE_MAX : whole[VALUE_W-1:0];
  endfunction

  function automatic logic [VALUE_W-1:0] distance(logic [VALUE_W-1:0] a, logic [VALUE_W-1:0] b);
    return (a > b) ? a - b : b - a;
  endfunction

  function automatic knob_result_t advance_history();
    logic [VALUE_W-1:0] delta_now;
    logic [VALUE_W-1:0] delta_prev;
    logic [VALUE_W-1:0] delta_span;
    logic               settled;
    knob_result_t       r;
    value_older = value_last;
    value_last  = value_now;
    value_now   = scale_median(group_median());
    // align the history while it still starts from zero
    if (value_older == '0) begin
      value_older = value_now;
      value_last  = value_now;
    end
    delta_now  = distance(value_now, value_last);
    delta_prev = distance(value_last, value_older);
    delta_span = distance(value_now, value_older);
    if (delta_now > change_limit) begin
      change_armed = 1'b1;
      // a swing that came straight back is no change
      if (delta_span < change_limit) change_armed = 1'b0;
    end
    settled = (delta_now < settle_limit) && (delta_prev < settle_limit);
    r.pad              = '0;
    r.reading          = value_now;
    r.previous_reading = value_last;
    r.changed_stable   = change_armed && settled;
    if (r.changed_stable) change_armed = 1'b0;
    return r;
  endfunction

  function automatic void report_mismatch(bit has_want, knob_result_t want, knob_result_t seen);
    errors++;
    if (errors <= 10) begin
      if (has_want) begin
        $display("result %0d: expected reading=%0d previous=%0d flag=%0b pad=%0h",
                 matched, want.reading, want.previous_reading, want.changed_stable, want.pad);
        $display("  got reading=%0d previous=%0d flag=%0b pad=%0h",
                 seen.reading, seen.previous_reading, seen.changed_stable, seen.pad);
      end else begin
        $display("result %0d: none expected, got reading=%0d previous=%0d flag=%0b",
                 matched, seen.reading, seen.previous_reading, seen.changed_stable);
      end
    end
  endfunction

  always @(posedge clk) begin : track
    knob_result_t seen;
    knob_result_t want;
    if (rst) begin
      knob_max     = 10'd1023;
      knob_gain    = 16'd256;
      change_limit = 10'd8;
      settle_limit = 10'd4;
      group_fill   = 0;
      value_now    = '0;
      value_last   = '0;
      value_older  = '0;
      change_armed = 1'b0;
      for (int i = 0; i < GROUP_SIZE; i++) group_store[i] = '0;
      expected_results.delete();
    end else begin
      if (cfg_we) begin
        case (reg_index_t'(cfg_index))
          REG_MAX_MEASURE:      knob_max     = cfg_data[SAMPLE_W-1:0];
          REG_SCALE_FACTOR:     knob_gain    = cfg_data[SCALE_W-1:0];
          REG_CHANGE_THRESHOLD: change_limit = cfg_data[VALUE_W-1:0];
          REG_STABLE_THRESHOLD: settle_limit = cfg_data[VALUE_W-1:0];
        endcase
      end
      // results first, so a result can never match an expectation pushed at the same edge
      if (m_tvalid && m_tready) begin
        seen = knob_result_t'(m_tdata);
        want = '0;
        if (expected_results.size() == 0) begin
          report_mismatch(1'b0, want, seen);
        end else begin
          want = expected_results.pop_front();
          if (seen.reading !== want.reading || seen.previous_reading !== want.previous_reading ||
              seen.changed_stable !== want.changed_stable || seen.pad !== want.pad)
            report_mismatch(1'b1, want, seen);
          if (want.changed_stable) pulses++;
        end
        matched++;
      end
      if (s_tvalid && s_tready) begin
        group_store[group_fill] = s_tdata[SAMPLE_W-1:0];
        group_fill++;
        if (group_fill == GROUP_SIZE) begin
          group_fill = 0;
          expected_results.push_back(advance_history());
        end
      end
    end
    mismatch_count  <= errors;
    pending_results <= expected_results.size();
    results_seen    <= matched;
    pulses_seen     <= pulses;
  end

endmodule

`default_nettype wire

FILE: tb/median_knob_change_detector_test.sv
// Testbench top for the median knob change detector: stimulus, idling, watchdog and verdict.
`default_nettype none

module median_knob_change_detector_test;
  import mkcd_pkg::*;

  localparam int SAMPLE_TOP     = (1 << SAMPLE_W) - 1;
  localparam int DRAIN_CYCLES   = GROUP_SIZE * (GROUP_SIZE + 1) + 16;
  localparam int HOLD_CYCLES    = 700;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int SETTINGS       = 6;
  localparam int GROUPS_PER_SET = 27;

  logic                clk       = 1'b0;
  logic                rst       = 1'b1;
  logic                cfg_we    = 1'b0;
  logic [INDEX_W-1:0]  cfg_index = '0;
  logic [CFG_W-1:0]    cfg_data  = '0;
  logic                s_tvalid  = 1'b0;
  logic                s_tready;
  logic [S_DATA_W-1:0] s_tdata   = '0;   // [9:0] sample, [15:10] zero
  logic                m_tvalid;
  logic                m_tready  = 1'b0;
  logic [M_DATA_W-1:0] m_tdata;          // [9:0] reading, [19:10] previous_reading,
                                         // [20] changed_stable, [23:21] zero

  int mismatch_count;
  int pending_results;
  int results_seen;
  int pulses_seen;

  int feed_gap_pct  = 0;
  int drain_gap_pct = 0;
  int samples_sent  = 0;
  int knob_level    = 512;
  int stall_cycles  = 0;
  int hold_left     = 0;
  logic hold_toggle = 1'b0;
  logic hold_seen   = 1'b0;

  median_knob_change_detector uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  knob_result_checker result_check (
    .clk             (clk),
    .rst             (rst),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .s_tvalid        (s_tvalid),
    .s_tready        (s_tready),
    .s_tdata         (s_tdata),
    .m_tvalid        (m_tvalid),
    .m_tready        (m_tready),
    .m_tdata         (m_tdata),
    .mismatch_count  (mismatch_count),
    .pending_results (pending_results),
    .results_seen    (results_seen),
    .pulses_seen     (pulses_seen)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // receiver: random backpressure, or a long hold-off when requested
  always @(posedge clk) begin
    if (hold_seen != hold_toggle) begin
      hold_seen <= hold_toggle;
      hold_left <= HOLD_CYCLES;
      m_tready  <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_tready  <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= drain_gap_pct);
    end
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("no transaction for %0d cycles", WATCHDOG_LIMIT);
        $display("** median_knob_change_detector: FAILED **");
        $finish;
      end
    end
  end

  function automatic int clip_sample(int v);
    return (v < 0) ? 0 : ((v > SAMPLE_TOP) ? SAMPLE_TOP : v);
  endfunction

  task automatic send_sample(input int v);
    while ($urandom_range(99) < feed_gap_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= S_DATA_W'(v);
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    samples_sent++;
  endtask

  // a knob that sits still, then steps or jumps, with spikes; some groups are all random
  task automatic send_group();
    int spikes;
    if ($urandom_range(99) < 15) begin
      for (int i = 0; i < GROUP_SIZE; i++) send_sample($urandom_range(SAMPLE_TOP));
    end else begin
      case ($urandom_range(9))
        0:       knob_level = $urandom_range(SAMPLE_TOP);
        1:       knob_level = $urandom_range(1) ? SAMPLE_TOP : 0;
        2, 3:    knob_level = clip_sample(knob_level + int'($urandom_range(40)) - 20);
        default: ;
      endcase
      spikes = ($urandom_range(3) == 0) ? $urandom_range(1, 4) : 0;
      for (int i = 0; i < GROUP_SIZE; i++) begin
        if ($urandom_range(GROUP_SIZE - 1) < spikes)
          send_sample($urandom_range(SAMPLE_TOP));
        else
          send_sample(clip_sample(knob_level + int'($urandom_range(4)) - 2));
      end
    end
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (pending_results != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input reg_index_t idx, input int value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_W'(value);
    @(posedge clk);
  endtask

  task automatic program_setting(input int k);
    int mx, gain, chg, settle;
    case (k)
      1:       begin mx = 900;  gain = 384;   chg = 20;   settle = 6;    end
      2:       begin mx = 1023; gain = 65535; chg = 0;    settle = 0;    end
      3:       begin mx = 0;    gain = 0;     chg = 1023; settle = 1023; end
      4:       begin mx = 600;  gain = 200;   chg = 5;    settle = 3;    end
      default: begin mx = 1000; gain = 300;   chg = 3;    settle = 10;   end
    endcase
    write_reg(REG_MAX_MEASURE, mx);
    write_reg(REG_SCALE_FACTOR, gain);
    write_reg(REG_CHANGE_THRESHOLD, chg);
    write_reg(REG_STABLE_THRESHOLD, settle);
    cfg_we <= 1'b0;
  endtask

  initial begin
    int directed [2*GROUP_SIZE];
    directed = '{1023, 0, 1023, 0, 512, 'h155, 'h2AA, 1023, 0, 1, 1022,
                 0, 0, 0, 0, 0, 0, 1023, 1023, 1023, 1023, 1023};
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    for (int k = 0; k < SETTINGS; k++) begin
      if (k > 0) begin
        wait_drained();
        program_setting(k);
      end
      if (k < 2) begin
        feed_gap_pct  = 27;
        drain_gap_pct = 57;
      end else if (k < 4) begin
        feed_gap_pct  = 57;
        drain_gap_pct = 27;
      end else begin
        feed_gap_pct  = 0;
        drain_gap_pct = 0;
      end
      // starve the output so the block fills up and stalls its input
      if (k == 2) hold_toggle <= ~hold_toggle;
      if (k == 0)
        for (int i = 0; i < 2 * GROUP_SIZE; i++) send_sample(directed[i]);
      repeat (GROUPS_PER_SET) send_group();
    end
    wait_drained();
    if (pending_results != 0) $display("%0d expected results never arrived", pending_results);
    $display("Covered %0d samples in %0d checked results over %0d register settings,",
             samples_sent, results_seen, SETTINGS);
    $display("with %0d changed-and-stable pulses, mixed idling and one long output hold-off.",
             pulses_seen);
    if (mismatch_count == 0 && pending_results == 0)
      $display("** median_knob_change_detector: PASSED **");
    else
      $display("** median_knob_change_detector: FAILED **");
    $finish;
  end

endmodule

`default_nettype wire

FILE: filelist.f
hdl/mkcd_pkg.sv
hdl/median_knob_change_detector.sv
tb/knob_result_checker.sv
tb/median_knob_change_detector_test.sv
